// File: hw/rtl/hse_pkg.sv
// shared types and constants of the heap sort engine
`timescale 1ns / 1ps

package hse_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

endpackage

// File: hw/rtl/heap_sort_engine.sv
// heap sort engine: key store, sift-down sequencer and output register
`timescale 1ns / 1ps

// Collects signed 32-bit keys and returns them in ascending order by heap sort.
//
// Input channel (key, is_last, in_valid, in_stall): one key per item. While
// keys are being collected in_stall is low and each item takes one cycle. A key
// that arrives when CAPACITY keys are already held is discarded, and every
// result of that run carries dropped. The item marked is_last closes the run.
// After it in_stall stays high for the whole sort and output phase.
//
// Sorting reuses a single compare/select unit and a two-read, one-write key
// store. Each sift-down level first reads both children from the registered
// store ports, then compares and writes back. A sift-down also fetches its
// top key first; in the extraction phase that key comes from swapping the
// root with the last unsorted key. For n keys there are n/2 + n - 1 sift-downs.
//
// Output channel (sorted_key, is_final, dropped, out_valid, out_stall): one
// result per stored key, smallest first, is_final on the last. Results come
// from a registered output stage, each after its own store read; while
// out_stall is high the result holds and the sequencer waits. Loading the
// final result clears the key count and the dropped flag, so the next run is
// accepted while that result still waits to be taken.
//
// Reset (rst_n low) clears the key count, the dropped flag and out_valid;
// the store itself is not cleared and needs no clearing pass.

module heap_sort_engine #(
    parameter int CAPACITY = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  hse_pkg::key_t  key,
    input  logic           is_last,
    input  logic           in_valid,
    output logic           in_stall,
    output hse_pkg::key_t  sorted_key,
    output logic           is_final,
    output logic           dropped,
    output logic           out_valid,
    input  logic           out_stall
);

    // position width (1..CAPACITY), child position width, store address width
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = PW + 1;
    localparam int AW = $clog2(CAPACITY);
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [PW-1:0] ONE_P = PW'(1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_SIFT_RD,
        S_SIFT_HOLD,
        S_SIFT_NEXT,
        S_SIFT_CMP,
        S_SWAP_RD,
        S_SWAP_WR,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    // key store, one-based positions held at address position - 1
    hse_pkg::key_t heap_store_reg [CAPACITY];
    hse_pkg::key_t rd_a_reg;
    hse_pkg::key_t rd_b_reg;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    hse_pkg::key_t  mem_wdata;
    logic [AW-1:0]  rd_a_addr;
    logic [AW-1:0]  rd_b_addr;

    state_t         state_reg,      state_next;
    logic           sort_phase_reg, sort_phase_next;   // 0 heap build, 1 extraction
    logic [PW-1:0]  count_reg,      count_next;
    logic           overflow_reg,   overflow_next;
    logic [PW-1:0]  idx_reg,        idx_next;
    logic [PW-1:0]  top_reg,        top_next;
    logic [PW-1:0]  limit_reg,      limit_next;
    hse_pkg::key_t  hold_reg,       hold_next;
    hse_pkg::key_t  out_key_reg,    out_key_next;
    logic           out_final_reg,  out_final_next;
    logic           out_drop_reg,   out_drop_next;
    logic           out_valid_reg,  out_valid_next;

    // datapath helpers
    logic [CW-1:0]  child;
    logic [CW-1:0]  child_m1;
    logic [CW-1:0]  limit_w;
    logic           has_right;
    logic           child_out;
    logic [PW-1:0]  top_m1;
    logic [PW-1:0]  idx_m1;
    logic [PW-1:0]  count_inc;
    hse_pkg::key_t  hold_cur;
    logic           a_lt_b;
    logic           hold_lt_a;
    logic           hold_lt_b;
    logic           take_right;
    logic           do_move;
    hse_pkg::key_t  child_val;
    logic [CW-1:0]  child_pos;
    logic           sift_done;
    logic           in_acc;
    logic           out_free;

    assign child     = {top_reg, 1'b0};
    assign child_m1  = child - CW'(1);
    assign limit_w   = {1'b0, limit_reg};
    assign has_right = child < limit_w;
    assign child_out = child > limit_w;
    assign top_m1    = top_reg - ONE_P;
    assign idx_m1    = idx_reg - ONE_P;
    assign count_inc = count_reg + ONE_P;
    assign hold_cur  = (state_reg == S_SIFT_HOLD) ? rd_a_reg : hold_reg;

    // the shared compare unit: three compares side by side, then a select
    assign a_lt_b     = rd_a_reg < rd_b_reg;
    assign hold_lt_a  = hold_reg < rd_a_reg;
    assign hold_lt_b  = hold_reg < rd_b_reg;
    assign take_right = has_right && a_lt_b;
    assign child_val  = take_right ? rd_b_reg : rd_a_reg;
    assign do_move    = take_right ? hold_lt_b : hold_lt_a;
    assign child_pos  = child + CW'(take_right);

    assign in_acc   = in_valid && (state_reg == S_LOAD);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall   = (state_reg != S_LOAD);
    assign sorted_key = out_key_reg;
    assign is_final   = out_final_reg;
    assign dropped    = out_drop_reg;
    assign out_valid  = out_valid_reg;

    // key store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_store_reg[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= heap_store_reg[rd_a_addr];
        rd_b_reg <= heap_store_reg[rd_b_addr];
    end

    // store port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = top_m1[AW-1:0];
        mem_wdata = hold_cur;
        rd_a_addr = top_m1[AW-1:0];
        rd_b_addr = child_m1[AW-1:0];
        unique case (state_reg)
            S_LOAD:
            begin
                mem_we    = in_acc && (count_reg < CAP_P);
                mem_waddr = count_reg[AW-1:0];
                mem_wdata = key;
            end
            S_SIFT_RD:
            begin
                rd_a_addr = top_m1[AW-1:0];
            end
            S_SIFT_HOLD, S_SIFT_NEXT:
            begin
                // leaf reached: park the held key
                mem_we    = child_out;
                rd_a_addr = child_m1[AW-1:0];
                rd_b_addr = has_right ? child[AW-1:0] : child_m1[AW-1:0];
            end
            S_SIFT_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = do_move ? child_val : hold_reg;
            end
            S_SWAP_RD:
            begin
                rd_a_addr = '0;
                rd_b_addr = idx_m1[AW-1:0];
            end
            S_SWAP_WR:
            begin
                // old root goes to the end of the unsorted part
                mem_we    = 1'b1;
                mem_waddr = idx_m1[AW-1:0];
                mem_wdata = rd_a_reg;
            end
            S_EMIT_RD, S_EMIT_LD:
            begin
                rd_a_addr = idx_m1[AW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign sift_done = ((state_reg == S_SIFT_HOLD || state_reg == S_SIFT_NEXT) && child_out)
                    || (state_reg == S_SIFT_CMP && !do_move);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sort_phase_next = sort_phase_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        idx_next        = idx_reg;
        top_next        = top_reg;
        limit_next      = limit_reg;
        hold_next       = hold_reg;
        out_key_next    = out_key_reg;
        out_final_next  = out_final_reg;
        out_drop_next   = out_drop_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CAP_P)
                    begin
                        count_next = count_inc;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        limit_next = (count_reg < CAP_P) ? count_inc : count_reg;
                        if (limit_next > ONE_P)
                        begin
                            sort_phase_next = 1'b0;
                            idx_next        = limit_next >> 1;
                            top_next        = limit_next >> 1;
                            state_next      = S_SIFT_RD;
                        end
                        else
                        begin
                            idx_next   = ONE_P;
                            state_next = S_EMIT_RD;
                        end
                    end
                end
            end
            S_SIFT_RD:
            begin
                state_next = S_SIFT_HOLD;
            end
            S_SIFT_HOLD, S_SIFT_NEXT:
            begin
                hold_next = hold_cur;
                if (!child_out)
                begin
                    state_next = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP:
            begin
                if (do_move)
                begin
                    top_next   = child_pos[PW-1:0];
                    state_next = S_SIFT_NEXT;
                end
            end
            S_SWAP_RD:
            begin
                state_next = S_SWAP_WR;
            end
            S_SWAP_WR:
            begin
                hold_next  = rd_b_reg;
                top_next   = ONE_P;
                limit_next = idx_m1;
                state_next = S_SIFT_NEXT;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_key_next   = rd_a_reg;
                    out_final_next = (idx_reg == count_reg);
                    out_drop_next  = overflow_reg;
                    out_valid_next = 1'b1;
                    if (idx_reg == count_reg)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE_P;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // end of one sift-down: pick the next root or move on
        if (sift_done)
        begin
            if (!sort_phase_reg)
            begin
                if (idx_reg > ONE_P)
                begin
                    idx_next   = idx_m1;
                    top_next   = idx_m1;
                    state_next = S_SIFT_RD;
                end
                else
                begin
                    sort_phase_next = 1'b1;
                    idx_next        = count_reg;
                    state_next      = S_SWAP_RD;
                end
            end
            else if (idx_m1 > ONE_P)
            begin
                idx_next   = idx_m1;
                state_next = S_SWAP_RD;
            end
            else
            begin
                idx_next   = ONE_P;
                state_next = S_EMIT_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            sort_phase_reg <= 1'b0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sort_phase_reg <= sort_phase_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        top_reg       <= top_next;
        limit_reg     <= limit_next;
        hold_reg      <= hold_next;
        out_key_reg   <= out_key_next;
        out_final_reg <= out_final_next;
        out_drop_reg  <= out_drop_next;
    end

    // the store never holds more keys than it has room for
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_P)
        else $error("key count beyond capacity");

    // a compare step only runs where the left child lies inside the heap
    a_cmp_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT_CMP) |-> (child <= limit_w))
        else $error("compare outside heap");

    // the sifted heap never reaches past the stored keys
    a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT_CMP || state_reg == S_SIFT_NEXT) |-> (limit_reg <= count_reg))
        else $error("heap limit beyond key count");

    // a new result only appears from the load step of the output phase
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall)) |-> $past(state_reg == S_EMIT_LD))
        else $error("result loaded outside output phase");

    // once the final result is loaded, the count is cleared for the next run
    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && out_free && idx_reg == count_reg) |=>
            (count_reg == '0 && !overflow_reg && state_reg == S_LOAD))
        else $error("run not cleared after final result");

endmodule
